// File: design/bse_pkg.sv
package bse_pkg;

  // Fixed-point format of every word: signed, FRAC_BITS fraction bits.
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned GRAY_W    = 8;
  localparam int unsigned ITER_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // One round unit per possible round (max_iter + 1 <= 256), plus one unit
  // that only runs the escape test on the last new z.
  localparam int unsigned NUM_UNITS = 257;

  // Escape radius 2, tested as |z|^2 >= 4.
  localparam logic [63:0] ESC_LIMIT = 64'd4 << FRAC_BITS;
  localparam logic [GRAY_W-1:0] GRAY_FULL = 8'd255;

  localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO = -66'sh0_8000_0000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_EDGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;

  typedef struct packed {
    logic signed [WORD_W-1:0] c_re;
    logic signed [WORD_W-1:0] c_im;
    logic signed [WORD_W-1:0] z_re;
    logic signed [WORD_W-1:0] z_im;
    logic [COUNT_W-1:0]       count;
    logic                     run;
  } point_t;

  typedef struct packed {
    logic [GRAY_W-1:0]  gray_level;
    logic [COUNT_W-1:0] escape_count;
  } result_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [65:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // floor(255 / (max_iter + 1)), as ranges of max_iter.
  function automatic logic [GRAY_W-1:0] gray_step(input logic [ITER_W-1:0] mi);
    logic [GRAY_W-1:0] s;
    if      (mi == 8'd0)  s = 8'd255;
    else if (mi == 8'd1)  s = 8'd127;
    else if (mi == 8'd2)  s = 8'd85;
    else if (mi == 8'd3)  s = 8'd63;
    else if (mi == 8'd4)  s = 8'd51;
    else if (mi == 8'd5)  s = 8'd42;
    else if (mi == 8'd6)  s = 8'd36;
    else if (mi == 8'd7)  s = 8'd31;
    else if (mi == 8'd8)  s = 8'd28;
    else if (mi == 8'd9)  s = 8'd25;
    else if (mi == 8'd10) s = 8'd23;
    else if (mi == 8'd11) s = 8'd21;
    else if (mi == 8'd12) s = 8'd19;
    else if (mi == 8'd13) s = 8'd18;
    else if (mi == 8'd14) s = 8'd17;
    else if (mi <= 8'd16) s = 8'd15;
    else if (mi == 8'd17) s = 8'd14;
    else if (mi == 8'd18) s = 8'd13;
    else if (mi <= 8'd20) s = 8'd12;
    else if (mi <= 8'd22) s = 8'd11;
    else if (mi <= 8'd24) s = 8'd10;
    else if (mi <= 8'd27) s = 8'd9;
    else if (mi <= 8'd30) s = 8'd8;
    else if (mi <= 8'd35) s = 8'd7;
    else if (mi <= 8'd41) s = 8'd6;
    else if (mi <= 8'd50) s = 8'd5;
    else if (mi <= 8'd62) s = 8'd4;
    else if (mi <= 8'd84) s = 8'd3;
    else if (mi <= 8'd126) s = 8'd2;
    else if (mi <= 8'd254) s = 8'd1;
    else s = 8'd0;
    return s;
  endfunction

endpackage

// File: design/burning_ship_escape_time.sv
// Burning Ship escape-time evaluator, one pixel coordinate per beat.
//
// Input stream s_axis: one beat per pixel, tdata carries pixel_x and pixel_y.
// The pixel maps to c = (left + x*x_step) + i(top - y*y_step), Q4.28, and
// z' = (|Re z| - i|Im z|)^2 + c runs from z = 0 for max_iter + 1 rounds.
// Output stream m_axis: one beat per pixel, in input order, with the number
// of rounds before escape and the grey level 255 - count*floor(255/rounds).
// Configuration: cfg_we_i writes cfg_index_i (0 left, 1 top, 2 x step,
// 3 y step, 4 max_iter); write only while no pixel is in flight.
//
// Throughput: one pixel per cycle while the output buffer is not full.
// Every possible round has its own unit (257 units of two stages each,
// 32x32 multipliers in the first stage). Pipeline: 2 coordinate stages
// + 514 round stages + 1 output buffer stage, the same for every max_iter.
// Stall: a two-entry output buffer sits behind the pipeline; when it is full
// the whole pipeline holds and s_axis_tready drops, nothing is lost.
// Reset clears all valid bits and the buffer and loads the default window.
module burning_ship_escape_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] pixel_x, [18:10] pixel_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [8:0] escape_count, [16:9] gray_level
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bse_pkg::*;

  logic signed [31:0] left_edge_q, top_edge_q;
  logic [30:0]        x_step_q, y_step_q;
  logic [7:0]         max_iter_q;

  logic    en;
  logic    vld   [NUM_UNITS+1];
  point_t  pts   [NUM_UNITS+1];
  result_t res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_edge_q <= 32'shD000_0000;
      top_edge_q  <= 32'sh2000_0000;
      x_step_q    <= 31'd2240073;
      y_step_q    <= 31'd2241632;
      max_iter_q  <= 8'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LEFT_EDGE: left_edge_q <= cfg_data_i;
        CFG_TOP_EDGE:  top_edge_q  <= cfg_data_i;
        CFG_X_STEP:    x_step_q    <= cfg_data_i[30:0];
        CFG_Y_STEP:    y_step_q    <= cfg_data_i[30:0];
        CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[7:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign s_axis_tready = en;

  bse_coord u_coord (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .pixel_x_i   (s_axis_tdata[9:0]),
    .pixel_y_i   (s_axis_tdata[18:10]),
    .left_edge_i (left_edge_q),
    .top_edge_i  (top_edge_q),
    .x_step_i    (x_step_q),
    .y_step_i    (y_step_q),
    .valid_o     (vld[0]),
    .point_o     (pts[0])
  );

  // Unit k tests z_k (k >= 1) and forms z_(k+1)
  for (genvar k = 0; k < NUM_UNITS; k++) begin : g_round
    bse_round #(.K(k)) u_round (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .max_iter_i (max_iter_q),
      .valid_i    (vld[k]),
      .point_i    (pts[k]),
      .valid_o    (vld[k+1]),
      .point_o    (pts[k+1])
    );
  end

  bse_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_iter_i (max_iter_q),
    .valid_i    (vld[NUM_UNITS]),
    .point_i    (pts[NUM_UNITS]),
    .en_o       (en),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .result_o   (res)
  );

  assign m_axis_tdata = {7'b0, res};

endmodule

// File: design/bse_coord.sv
module bse_coord (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [9:0]                pixel_x_i,
  input  logic [8:0]                pixel_y_i,
  input  logic signed [31:0]        left_edge_i,
  input  logic signed [31:0]        top_edge_i,
  input  logic [30:0]               x_step_i,
  input  logic [30:0]               y_step_i,
  output logic                      valid_o,
  output bse_pkg::point_t           point_o
);
  import bse_pkg::*;

  logic        vld1_q;
  logic [40:0] prod_x_q;
  logic [39:0] prod_y_q;
  logic signed [65:0] re_sum;
  logic signed [65:0] im_sum;

  // Stage 1: column and row offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld1_q  <= valid_i;
      valid_o <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= {31'b0, pixel_x_i} * {10'b0, x_step_i};
      prod_y_q <= {31'b0, pixel_y_i} * {9'b0, y_step_i};
    end
  end

  // Stage 2: add the window origin, saturate, start z at zero
  assign re_sum = $signed({{34{left_edge_i[31]}}, left_edge_i}) + $signed({25'b0, prod_x_q});
  assign im_sum = $signed({{34{top_edge_i[31]}}, top_edge_i}) - $signed({26'b0, prod_y_q});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      point_o.c_re  <= sat_word(re_sum);
      point_o.c_im  <= sat_word(im_sum);
      point_o.z_re  <= '0;
      point_o.z_im  <= '0;
      point_o.count <= '0;
      point_o.run   <= 1'b1;
    end
  end

endmodule

// File: design/bse_round.sv
module bse_round #(
  parameter int unsigned K = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            max_iter_i,
  input  logic                  valid_i,
  input  bse_pkg::point_t       point_i,
  output logic                  valid_o,
  output bse_pkg::point_t       point_o
);
  import bse_pkg::*;

  localparam logic [COUNT_W-1:0] KV = COUNT_W'(K);

  logic        vld1_q;
  point_t      pt1_q;
  logic [63:0] aa_q, bb_q, ab_q;
  logic [31:0] mag_re, mag_im;
  logic [63:0] a2, b2, ab2;
  logic [64:0] mag2;
  logic [COUNT_W-1:0] rounds;
  logic        run_next;
  logic signed [65:0] re_sum, im_sum;

  assign mag_re = point_i.z_re[31] ? (~point_i.z_re + 32'd1) : point_i.z_re;
  assign mag_im = point_i.z_im[31] ? (~point_i.z_im + 32'd1) : point_i.z_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q  <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      vld1_q  <= valid_i;
      valid_o <= vld1_q;
    end
  end

  // Stage 1: square the magnitudes and form the cross product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt1_q <= point_i;
      aa_q  <= {32'b0, mag_re} * {32'b0, mag_re};
      bb_q  <= {32'b0, mag_im} * {32'b0, mag_im};
      ab_q  <= {32'b0, mag_re} * {32'b0, mag_im};
    end
  end

  // Stage 2: escape test on the incoming z, then the next z
  assign a2     = aa_q >> FRAC_BITS;
  assign b2     = bb_q >> FRAC_BITS;
  assign ab2    = {ab_q[62:0], 1'b0} >> FRAC_BITS;
  assign mag2   = {1'b0, a2} + {1'b0, b2};
  assign rounds = {1'b0, max_iter_i} + 9'd1;

  // The first unit starts from z = 0 and has nothing to test
  assign run_next = pt1_q.run &&
                    ((K == 0) || ((KV <= rounds) && (mag2 < {1'b0, ESC_LIMIT})));

  assign re_sum = $signed({2'b0, a2}) - $signed({2'b0, b2}) + 66'(pt1_q.c_re);
  assign im_sum = 66'(pt1_q.c_im) - $signed({2'b0, ab2});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      point_o.c_re  <= pt1_q.c_re;
      point_o.c_im  <= pt1_q.c_im;
      point_o.z_re  <= sat_word(re_sum);
      point_o.z_im  <= sat_word(im_sum);
      point_o.run   <= run_next;
      point_o.count <= (K != 0 && run_next) ? pt1_q.count + 9'd1 : pt1_q.count;
    end
  end

endmodule

// File: design/bse_out.sv
module bse_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            max_iter_i,
  input  logic                  valid_i,
  input  bse_pkg::point_t       point_i,
  output logic                  en_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output bse_pkg::result_t      result_o
);
  import bse_pkg::*;

  result_t     buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  logic [16:0] shade;
  result_t     res;

  // Hold the whole pipeline only when both buffer entries are taken
  assign en_o    = (cnt_q != 2'd2);
  assign push    = en_o && valid_i;
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign result_o = buf_q[rd_ptr_q];

  assign shade            = {8'b0, point_i.count} * {9'b0, gray_step(max_iter_i)};
  assign res.escape_count = point_i.count;
  assign res.gray_level   = GRAY_FULL - shade[GRAY_W-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

endmodule

// File: design/bse_checker.sv
module bse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Count never exceeds the largest number of rounds
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:0] <= 9'd256)
    else $error("escape_count out of range");

  // A pixel that escapes in the first round is full white
  a_gray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8:0] == 9'd0 |-> m_axis_tdata[16:9] == 8'd255)
    else $error("gray level wrong for zero count");

  // Input backpressure only while results wait at the output
  a_hold_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");

endmodule

bind burning_ship_escape_time bse_checker u_bse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
